### src/rre_pkg.sv
// Shared constants, codes and controller/datapath signal groups for the
// record-and-replay echo block. No dependencies.
package rre_pkg;

  localparam int FRAME_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);

  localparam int WORD_W      = 48;
  localparam int FUNC_W      = 3;
  localparam int TICK_W      = 8;
  localparam int DELAY_W     = 16;
  localparam int PERIOD_W    = 8;
  localparam int WAIT_W      = 16;
  localparam int PLAY_W      = 24;
  localparam int MAX_OUT     = 14;
  localparam int BURST_W     = $clog2(MAX_OUT + 1);
  localparam int DIV_CNT_W   = $clog2(PLAY_W);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [DELAY_W-1:0]  DELAY_RESET  = 16'd1000;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd20;

  localparam logic [FUNC_W-1:0] FUNC_HEADER = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_FRAME  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_END    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_DELAY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 1'b1;

  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_RECEIVE  = 2'd1;
  localparam logic [1:0] MODE_WAIT     = 2'd2;
  localparam logic [1:0] MODE_TRANSMIT = 2'd3;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;  // capture the accepted input item
    logic exec;       // apply the captured item to the mode and counters
    logic start;      // emit the playback-start result and enter playback (idle if nothing is stored)
    logic div_step;   // one step of the due-frame divider
    logic rd;         // read the next stored frame
    logic emit;       // emit the frame read in the previous step
  } rre_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tick_expire;  // captured tick ends the reply wait
    logic tick_play;    // captured tick arrives during playback
    logic div_done;     // divider finishes in this step
    logic more;         // another frame is due in this burst
    logic emit_last;    // the frame now being emitted closes the burst
    logic out_free;     // the result register can take a new result
  } rre_stat_t;

endpackage

### src/rre_in_if.sv
// Input item channel: valid/ready handshake with the input fields.
// Depends on rre_pkg.
interface rre_in_if import rre_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [WORD_W-1:0]   frame_word_a;
  logic [WORD_W-1:0]   frame_word_b;
  logic                frame_is_end;
  logic [TICK_W-1:0]   tick_ms;

  modport source (output valid, func, frame_word_a, frame_word_b, frame_is_end, tick_ms,
                  input ready);
  modport sink (input valid, func, frame_word_a, frame_word_b, frame_is_end, tick_ms,
                output ready);
endinterface

### src/rre_out_if.sv
// Result channel: valid/ready handshake with the result fields.
// Depends on rre_pkg.
interface rre_out_if import rre_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [WORD_W-1:0] out_word_a;
  logic [WORD_W-1:0] out_word_b;
  logic              out_is_end;
  logic              last;

  modport source (output valid, kind, out_word_a, out_word_b, out_is_end, last,
                  input ready);
  modport sink (input valid, kind, out_word_a, out_word_b, out_is_end, last,
                output ready);
endinterface

### src/rre_ctrl.sv
// Controller state machine of the record-and-replay echo block.
// Depends on rre_pkg; drives rre_dp through rre_cmd_t and reads rre_stat_t.
module rre_ctrl import rre_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  rre_stat_t stat,
  output rre_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.tick_expire) begin
          state_next = S_START;
        end else if (stat.tick_play) begin
          state_next = S_DIV;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_START: begin
        if (stat.out_free) begin
          cmd.start  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (stat.more) begin
          cmd.rd     = 1'b1;
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = stat.emit_last ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### src/rre_dp.sv
// Datapath of the record-and-replay echo block: configuration, mode and
// counters, frame store, due-frame divider and result register. Depends on rre_pkg.
module rre_dp import rre_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [FUNC_W-1:0]     func,
  input  logic [WORD_W-1:0]     frame_word_a,
  input  logic [WORD_W-1:0]     frame_word_b,
  input  logic                  frame_is_end,
  input  logic [TICK_W-1:0]     tick_ms,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic                  kind,
  output logic [WORD_W-1:0]     out_word_a,
  output logic [WORD_W-1:0]     out_word_b,
  output logic                  out_is_end,
  output logic                  last,
  input  rre_cmd_t              cmd,
  output rre_stat_t             stat
);

  logic [DELAY_W-1:0]   reply_delay;
  logic [PERIOD_W-1:0]  frame_period;

  logic [1:0]           mode;
  logic [CNT_W-1:0]     write_count;
  logic [CNT_W-1:0]     read_count;
  logic [WAIT_W-1:0]    wait_ms;
  logic [PLAY_W-1:0]    play_ms;

  logic [FUNC_W-1:0]    f_func;
  logic [WORD_W-1:0]    f_wa;
  logic [WORD_W-1:0]    f_wb;
  logic                 f_end;
  logic [TICK_W-1:0]    f_tick;

  logic [PLAY_W-1:0]    div_num;
  logic [PERIOD_W-1:0]  div_rem;
  logic [PERIOD_W-1:0]  div_den;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [BURST_W-1:0]   burst;

  logic [2*WORD_W-1:0]  mem [FRAME_DEPTH];
  logic [2*WORD_W-1:0]  rd_data;

  logic [WAIT_W:0]      wait_sum;
  logic [WAIT_W-1:0]    wait_sat;
  logic [PLAY_W:0]      play_sum;
  logic [PLAY_W-1:0]    play_sat;
  logic [PERIOD_W-1:0]  period_eff;
  logic                 frame_wr;
  logic [PERIOD_W:0]    rem_sh;
  logic                 rem_ge;
  logic [PERIOD_W:0]    rem_sub;
  logic [CNT_W-1:0]     rc_inc;
  logic [BURST_W-1:0]   burst_inc;
  logic                 emit_end;
  logic                 more_next;

  always_comb begin
    wait_sum   = {1'b0, wait_ms} + (WAIT_W+1)'(f_tick);
    wait_sat   = wait_sum[WAIT_W] ? '1 : wait_sum[WAIT_W-1:0];
    play_sum   = {1'b0, play_ms} + (PLAY_W+1)'(f_tick);
    play_sat   = play_sum[PLAY_W] ? '1 : play_sum[PLAY_W-1:0];
    period_eff = (frame_period == '0) ? PERIOD_W'(1) : frame_period;
    frame_wr   = cmd.exec && (f_func == FUNC_FRAME) && (mode == MODE_RECEIVE) &&
                 (write_count < CNT_W'(FRAME_DEPTH));

    // Restoring division, one quotient bit per step; quotient shifts into div_num.
    rem_sh  = {div_rem, div_num[PLAY_W-1]};
    rem_ge  = (rem_sh >= {1'b0, div_den});
    rem_sub = rem_sh - {1'b0, div_den};

    rc_inc    = read_count + CNT_W'(1);
    burst_inc = burst + BURST_W'(1);
    emit_end  = (rc_inc == write_count);
    more_next = (PLAY_W'(rc_inc) < div_num) && (rc_inc < write_count) &&
                (burst_inc < BURST_W'(MAX_OUT));

    stat.tick_expire = (f_func == FUNC_TICK) && (mode == MODE_WAIT) &&
                       (wait_sat >= reply_delay);
    stat.tick_play   = (f_func == FUNC_TICK) && (mode == MODE_TRANSMIT);
    stat.div_done    = (div_cnt == DIV_CNT_W'(PLAY_W - 1));
    stat.more        = (PLAY_W'(read_count) < div_num) && (read_count < write_count) &&
                       (burst < BURST_W'(MAX_OUT));
    stat.emit_last   = emit_end || !more_next;
    stat.out_free    = !res_valid || res_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_delay  <= DELAY_RESET;
      frame_period <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REPLY_DELAY:  reply_delay  <= cfg_data[DELAY_W-1:0];
        CFG_FRAME_PERIOD: frame_period <= cfg_data[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      f_func <= func;
      f_wa   <= frame_word_a;
      f_wb   <= frame_word_b;
      f_end  <= frame_is_end;
      f_tick <= tick_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_wr) begin
      mem[write_count[ADDR_W-1:0]] <= {f_wa, f_wb};
    end
    if (cmd.rd) begin
      rd_data <= mem[read_count[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && stat.tick_play) begin
      div_num <= play_sat;
      div_rem <= '0;
      div_den <= period_eff;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_num <= {div_num[PLAY_W-2:0], rem_ge};
      div_rem <= rem_ge ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      write_count <= '0;
      read_count  <= '0;
      wait_ms     <= '0;
      play_ms     <= '0;
      burst       <= '0;
    end else if (cmd.exec) begin
      case (f_func)
        FUNC_HEADER: begin
          if (mode == MODE_IDLE) begin
            write_count <= '0;
            read_count  <= '0;
            mode        <= MODE_RECEIVE;
          end
        end
        FUNC_FRAME: begin
          if (mode == MODE_RECEIVE) begin
            if (frame_wr) begin
              write_count <= write_count + CNT_W'(1);
            end
            if (f_end) begin
              wait_ms <= '0;
              mode    <= MODE_WAIT;
            end
          end
        end
        FUNC_END: begin
          if (mode == MODE_RECEIVE) begin
            wait_ms <= '0;
            mode    <= MODE_WAIT;
          end
        end
        FUNC_TICK: begin
          if (mode == MODE_WAIT) begin
            wait_ms <= wait_sat;
          end else if (mode == MODE_TRANSMIT) begin
            play_ms <= play_sat;
            burst   <= '0;
          end
        end
        FUNC_CANCEL: begin
          mode        <= MODE_IDLE;
          write_count <= '0;
          read_count  <= '0;
          wait_ms     <= '0;
          play_ms     <= '0;
        end
        default: begin
        end
      endcase
    end else if (cmd.start) begin
      wait_ms    <= '0;
      play_ms    <= '0;
      read_count <= '0;
      if (write_count == '0) begin
        mode <= MODE_IDLE;
      end else begin
        mode <= MODE_TRANSMIT;
      end
    end else if (cmd.emit) begin
      burst <= burst_inc;
      if (emit_end) begin
        // The final frame has gone out: the recording is finished.
        mode        <= MODE_IDLE;
        write_count <= '0;
        read_count  <= '0;
        wait_ms     <= '0;
        play_ms     <= '0;
      end else begin
        read_count <= rc_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.start || cmd.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind       <= KIND_START;
      out_word_a <= '0;
      out_word_b <= '0;
      out_is_end <= 1'b0;
      last       <= 1'b1;
    end else if (cmd.emit) begin
      kind       <= KIND_FRAME;
      out_word_a <= rd_data[2*WORD_W-1:WORD_W];
      out_word_b <= rd_data[WORD_W-1:0];
      out_is_end <= emit_end;
      last       <= stat.emit_last;
    end
  end

`ifndef ASSERT_OFF
  a_write_bound: assert property (@(posedge clk) disable iff (rst)
    write_count <= CNT_W'(FRAME_DEPTH))
    else $error("write count beyond store depth");

  a_read_behind_write: assert property (@(posedge clk) disable iff (rst)
    read_count <= write_count)
    else $error("read count passed write count");

  a_burst_bound: assert property (@(posedge clk) disable iff (rst)
    burst <= BURST_W'(MAX_OUT))
    else $error("too many frames in one burst");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.start || cmd.emit) |-> (!res_valid || res_ready))
    else $error("result register overwritten before transfer");
`endif

endmodule

### src/record_and_replay_echo.sv
// Top level of the record-and-replay echo block: controller plus datapath.
// Depends on rre_pkg, rre_in_if, rre_out_if, rre_ctrl and rre_dp.
//
//   Port      Direction  Contents
//   item      sink       func, frame_word_a/b, frame_is_end, tick_ms
//   result    source     kind, out_word_a/b, out_is_end, last
//   cfg_*     write      0 reply_delay_ms, 1 frame_period_ms
//
// Each item is taken in the idle state and applied in the exec state. A tick that
// ends the reply wait then loads the playback-start result. A tick during playback
// then runs the bit-serial due-frame divider, then a store read and a result load
// for each released frame, or only a read-state check when no frame is due. Reset
// is synchronous and active high; the store needs no clearing. A stalled result
// stalls only the step that loads the next one.
module record_and_replay_echo import rre_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rre_in_if.sink                item,
  rre_out_if.source             result
);

  rre_cmd_t  cmd;
  rre_stat_t stat;
  logic      item_ready;

  assign item.ready = item_ready;

  rre_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rre_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .func         (item.func),
    .frame_word_a (item.frame_word_a),
    .frame_word_b (item.frame_word_b),
    .frame_is_end (item.frame_is_end),
    .tick_ms      (item.tick_ms),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .kind         (result.kind),
    .out_word_a   (result.out_word_a),
    .out_word_b   (result.out_word_b),
    .out_is_end   (result.out_is_end),
    .last         (result.last),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

### verif/rre_echo_checker.sv
// Checker for the record-and-replay echo block: follows the register writes and
// every item transfer, predicts the replayed results and compares each result transfer.
// Depends on rre_pkg, rre_in_if and rre_out_if.
module rre_echo_checker import rre_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rre_in_if                     item,
  rre_out_if                    result,
  output int                    fail_count,
  output int                    outstanding
);

  typedef struct {
    logic              kind;
    logic [WORD_W-1:0] word_a;
    logic [WORD_W-1:0] word_b;
    logic              is_end;
    logic              last;
  } echo_t;

  echo_t echo_q[$];

  logic [DELAY_W-1:0]  reply_delay;
  logic [PERIOD_W-1:0] frame_period;
  logic [1:0]          mode;
  logic [CNT_W-1:0]    wr_cnt;
  logic [CNT_W-1:0]    rd_cnt;
  logic [WAIT_W-1:0]   wait_ms;
  logic [PLAY_W-1:0]   play_ms;
  logic [WORD_W-1:0]   store_hi [FRAME_DEPTH];
  logic [WORD_W-1:0]   store_lo [FRAME_DEPTH];

  task automatic clear_run();
    mode    = MODE_IDLE;
    wr_cnt  = '0;
    rd_cnt  = '0;
    wait_ms = '0;
    play_ms = '0;
  endtask

  task automatic add_echo(input logic k, input logic [WORD_W-1:0] a,
                          input logic [WORD_W-1:0] b, input logic e);
    echo_t x;
    x.kind   = k;
    x.word_a = a;
    x.word_b = b;
    x.is_end = e;
    x.last   = 1'b0;
    echo_q.push_back(x);
  endtask

  // Applies one item to the predicted state and queues the results it releases.
  task automatic step_echo(input logic [FUNC_W-1:0] f, input logic [WORD_W-1:0] wa,
                           input logic [WORD_W-1:0] wb, input logic e,
                           input logic [TICK_W-1:0] t);
    logic [WAIT_W:0]     wsum;
    logic [PLAY_W:0]     psum;
    logic [PLAY_W-1:0]   due;
    logic [PERIOD_W-1:0] per;
    logic [ADDR_W-1:0]   idx;
    int                  made;
    made = 0;
    case (f)
      FUNC_HEADER: begin
        if (mode == MODE_IDLE) begin
          wr_cnt = '0;
          rd_cnt = '0;
          mode   = MODE_RECEIVE;
        end
      end
      FUNC_FRAME: begin
        if (mode == MODE_RECEIVE) begin
          // Frames beyond the store size are dropped, but the end mark still counts.
          if (wr_cnt < CNT_W'(FRAME_DEPTH)) begin
            store_hi[wr_cnt[ADDR_W-1:0]] = wa;
            store_lo[wr_cnt[ADDR_W-1:0]] = wb;
            wr_cnt++;
          end
          if (e) begin
            wait_ms = '0;
            mode    = MODE_WAIT;
          end
        end
      end
      FUNC_END: begin
        if (mode == MODE_RECEIVE) begin
          wait_ms = '0;
          mode    = MODE_WAIT;
        end
      end
      FUNC_TICK: begin
        if (mode == MODE_WAIT) begin
          wsum    = {1'b0, wait_ms} + (WAIT_W+1)'(t);
          wait_ms = wsum[WAIT_W] ? '1 : wsum[WAIT_W-1:0];
          if (wait_ms >= reply_delay) begin
            add_echo(KIND_START, '0, '0, 1'b0);
            made++;
            wait_ms = '0;
            play_ms = '0;
            rd_cnt  = '0;
            if (wr_cnt == '0) begin
              clear_run();
            end else begin
              mode = MODE_TRANSMIT;
            end
          end
        end else if (mode == MODE_TRANSMIT) begin
          per     = (frame_period == '0) ? PERIOD_W'(1) : frame_period;
          psum    = {1'b0, play_ms} + (PLAY_W+1)'(t);
          play_ms = psum[PLAY_W] ? '1 : psum[PLAY_W-1:0];
          due     = play_ms / PLAY_W'(per);
          while (PLAY_W'(rd_cnt) < due && rd_cnt < wr_cnt && made < MAX_OUT) begin
            idx = rd_cnt[ADDR_W-1:0];
            rd_cnt++;
            add_echo(KIND_FRAME, store_hi[idx], store_lo[idx], rd_cnt == wr_cnt);
            made++;
            if (rd_cnt == wr_cnt) begin
              clear_run();
              break;
            end
          end
        end
      end
      FUNC_CANCEL: begin
        clear_run();
      end
      default: begin
      end
    endcase
    if (made > 0) begin
      echo_q[echo_q.size() - 1].last = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    int    errs;
    echo_t exp_r;
    errs = 0;
    if (rst) begin
      reply_delay  = DELAY_RESET;
      frame_period = PERIOD_RESET;
      clear_run();
      echo_q.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (echo_q.size() == 0) begin
          $error("result transfer with nothing expected: kind %0d, out_is_end %0d",
                 result.kind, result.out_is_end);
          errs++;
        end else begin
          exp_r = echo_q.pop_front();
          if (result.kind !== exp_r.kind) begin
            $error("kind: expected %0d, got %0d", exp_r.kind, result.kind);
            errs++;
          end
          if (result.out_word_a !== exp_r.word_a) begin
            $error("out_word_a: expected %h, got %h", exp_r.word_a, result.out_word_a);
            errs++;
          end
          if (result.out_word_b !== exp_r.word_b) begin
            $error("out_word_b: expected %h, got %h", exp_r.word_b, result.out_word_b);
            errs++;
          end
          if (result.out_is_end !== exp_r.is_end) begin
            $error("out_is_end: expected %0d, got %0d", exp_r.is_end, result.out_is_end);
            errs++;
          end
          if (result.last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, result.last);
            errs++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_REPLY_DELAY:  reply_delay  = cfg_data[DELAY_W-1:0];
          CFG_FRAME_PERIOD: frame_period = cfg_data[PERIOD_W-1:0];
          default: begin
          end
        endcase
      end
      if (item.valid && item.ready) begin
        step_echo(item.func, item.frame_word_a, item.frame_word_b, item.frame_is_end,
                  item.tick_ms);
      end
    end
    fail_count  <= fail_count + errs;
    outstanding <= echo_q.size();
  end

endmodule

### verif/tb_record_and_replay_echo.sv
// Testbench top for the record-and-replay echo block: drives recording sessions
// and register settings, stalls the result side, and gives the verdict.
// Depends on rre_pkg, rre_in_if, rre_out_if, rre_echo_checker and the block.
module tb_record_and_replay_echo;
  import rre_pkg::*;

  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 100;
  localparam int RANDOM_PHASES  = 4;
  localparam int WAIT_MAX_MS    = 65535;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int outstanding;
  int quiet_cycles;
  int burst_left;
  int sent_items;
  int cur_delay;
  int cur_period;

  rre_in_if  item_ch ();
  rre_out_if res_ch ();

  record_and_replay_echo DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (res_ch)
  );

  rre_echo_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item        (item_ch),
    .result      (res_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: each stretch picks a stall style, from always ready to long stalls.
  initial begin
    int style;
    int left;
    int hold;
    res_ch.ready = 1'b0;
    left = 0;
    hold = 0;
    style = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        style = $urandom_range(3);
        left  = $urandom_range(200, 10);
      end
      left--;
      case (style)
        0: res_ch.ready = 1'b1;
        1: res_ch.ready = 1'($urandom_range(1));
        2: res_ch.ready = ($urandom_range(3) == 0);
        default: begin
          if (hold == 0) begin
            hold = $urandom_range(20, 1);
            res_ch.ready = ~res_ch.ready;
          end
          hold--;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("** record_and_replay_echo: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[WORD_W-1:0];
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  // Valid stays high so a following item in the same burst goes out back to back.
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [WORD_W-1:0] wa,
                           input logic [WORD_W-1:0] wb, input logic e,
                           input logic [TICK_W-1:0] t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(16, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 1);
      if (gap > 0) begin
        item_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item_ch.valid        = 1'b1;
    item_ch.func         = f;
    item_ch.frame_word_a = wa;
    item_ch.frame_word_b = wb;
    item_ch.frame_is_end = e;
    item_ch.tick_ms      = t;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_op(input logic [FUNC_W-1:0] f, input logic [TICK_W-1:0] t);
    send_item(f, rand_word(), rand_word(), 1'($urandom_range(1)), t);
  endtask

  // Items the block must ignore in the current mode, plus unused function codes.
  task automatic send_noise(input bit in_receive);
    logic [FUNC_W-1:0] f;
    case ($urandom_range(3))
      0: f = FUNC_HEADER;
      1: f = in_receive ? FUNC_TICK : FUNC_FRAME;
      2: f = in_receive ? FUNC_HEADER : FUNC_END;
      default: f = FUNC_CANCEL + FUNC_W'($urandom_range(3, 1));
    endcase
    send_op(f, TICK_W'($urandom_range(255)));
  endtask

  task automatic wait_idle();
    item_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_timing(input int delay, input int period);
    wait_idle();
    write_reg(CFG_REPLY_DELAY, delay);
    write_reg(CFG_FRAME_PERIOD, period);
    cur_delay  = delay;
    cur_period = period;
  endtask

  function automatic int pick_count(input int most);
    case ($urandom_range(9))
      0: return 0;
      1, 2, 3, 4, 5, 6: return $urandom_range(8, 1);
      default: return $urandom_range(most, 9);
    endcase
  endfunction

  // One recording: header, frames, end, reply wait and playback. Sends ticks
  // until the whole recording should have been replayed, unless it is cancelled.
  task automatic echo_session(input int n_frames, input int tick_lo, input int tick_hi,
                              input bit may_break);
    int stored;
    int played;
    int wait_acc;
    int play_acc;
    int due;
    int t;
    int period_eff;
    bit by_flag;
    by_flag = (n_frames > 0) && ($urandom_range(1) == 1);
    send_op(FUNC_HEADER, TICK_W'($urandom_range(255)));
    sent_items++;
    stored = 0;
    for (int i = 0; i < n_frames; i++) begin
      if ($urandom_range(15) == 0) send_noise(1'b1);
      send_item(FUNC_FRAME, rand_word(), rand_word(), by_flag && (i == n_frames - 1),
                TICK_W'($urandom_range(255)));
      sent_items++;
      if (stored < FRAME_DEPTH) stored++;
    end
    if (may_break && $urandom_range(11) == 0) begin
      send_op(FUNC_CANCEL, TICK_W'($urandom_range(255)));
      sent_items++;
      return;
    end
    if (!by_flag) begin
      send_op(FUNC_END, TICK_W'($urandom_range(255)));
      sent_items++;
    end
    wait_acc = 0;
    do begin
      if ($urandom_range(15) == 0) send_noise(1'b0);
      if (may_break && $urandom_range(39) == 0) begin
        send_op(FUNC_CANCEL, TICK_W'($urandom_range(255)));
        sent_items++;
        return;
      end
      t = $urandom_range(tick_hi, tick_lo);
      send_op(FUNC_TICK, TICK_W'(t));
      sent_items++;
      wait_acc = (wait_acc + t > WAIT_MAX_MS) ? WAIT_MAX_MS : wait_acc + t;
    end while (wait_acc < cur_delay);
    period_eff = (cur_period == 0) ? 1 : cur_period;
    played = 0;
    play_acc = 0;
    while (played < stored) begin
      if ($urandom_range(15) == 0) send_noise(1'b0);
      if (may_break && $urandom_range(59) == 0) begin
        send_op(FUNC_CANCEL, TICK_W'($urandom_range(255)));
        sent_items++;
        return;
      end
      t = $urandom_range(tick_hi, tick_lo);
      send_op(FUNC_TICK, TICK_W'(t));
      sent_items++;
      play_acc += t;
      due = play_acc / period_eff;
      if (due > played) played = (due < played + MAX_OUT) ? due : played + MAX_OUT;
      if (played > stored) played = stored;
    end
  endtask

  initial begin
    int phase_start;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = CFG_REPLY_DELAY;
    cfg_data             = '0;
    item_ch.valid        = 1'b0;
    item_ch.func         = FUNC_HEADER;
    item_ch.frame_word_a = '0;
    item_ch.frame_word_b = '0;
    item_ch.frame_is_end = 1'b0;
    item_ch.tick_ms      = '0;
    burst_left           = 0;
    sent_items           = 0;
    cur_delay            = int'(DELAY_RESET);
    cur_period           = int'(PERIOD_RESET);
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Reset timing: items in the wrong mode, unused codes, then a two-frame echo.
    send_op(FUNC_TICK, 8'd7);
    send_op(FUNC_CANCEL + FUNC_W'(1), 8'd0);
    send_op(FUNC_CANCEL + FUNC_W'(3), 8'hFF);
    send_item(FUNC_FRAME, rand_word(), rand_word(), 1'b1, 8'd0);
    send_op(FUNC_CANCEL, 8'd0);
    send_op(FUNC_HEADER, 8'd0);
    send_op(FUNC_HEADER, 8'd0);
    send_op(FUNC_TICK, 8'hFF);
    send_item(FUNC_FRAME, '1, '1, 1'b0, 8'hFF);
    send_item(FUNC_FRAME, '0, '0, 1'b1, 8'h00);
    send_item(FUNC_FRAME, rand_word(), rand_word(), 1'b0, 8'd0);
    repeat (4) send_op(FUNC_TICK, 8'hFF);
    send_op(FUNC_TICK, 8'd40);
    send_op(FUNC_HEADER, 8'd0);
    send_op(FUNC_CANCEL, 8'd0);

    // No reply delay and a zero frame period; first an empty recording.
    set_timing(0, 0);
    send_op(FUNC_HEADER, 8'd0);
    send_op(FUNC_END, 8'd0);
    send_op(FUNC_TICK, 8'd0);
    send_op(FUNC_HEADER, 8'd0);
    send_item(FUNC_FRAME, rand_word(), rand_word(), 1'b1, 8'd0);
    send_op(FUNC_TICK, 8'd0);
    send_op(FUNC_TICK, 8'd0);
    send_op(FUNC_TICK, 8'd1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_timing($urandom_range(300), $urandom_range(40, 1));
        1: set_timing(0, 1);
        2: set_timing($urandom_range(600), $urandom_range(255));
        default: set_timing($urandom_range(150), $urandom_range(10));
      endcase
      phase_start = sent_items;
      while (sent_items - phase_start < PHASE_ITEMS) begin
        echo_session(pick_count((p == 1) ? 45 : 20), 0, 255, 1'b1);
      end
    end

    wait_idle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("** record_and_replay_echo: PASSED **");
    end else begin
      $display("** record_and_replay_echo: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
src/rre_pkg.sv
src/rre_in_if.sv
src/rre_out_if.sv
src/rre_ctrl.sv
src/rre_dp.sv
src/record_and_replay_echo.sv
verif/rre_echo_checker.sv
verif/tb_record_and_replay_echo.sv
